// ----- hdl/mmac_pkg.sv -----
// shared constants, types and helpers of the matrix multiply-accumulate engine
package mmac_pkg;

	localparam int MAX_DIM     = 8;
	localparam int FRAC_BITS   = 16;
	localparam int DATA_W      = 32;
	localparam int FIELD_IDX_W = 3;
	localparam int FUNC_W      = 3;
	localparam int CNT_W       = 4;
	localparam int CFG_IDX_W   = 3;
	localparam int TDATA_W     = 40;

	localparam int IDX_W     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int DIM_W     = $clog2(MAX_DIM + 1);
	localparam int DEPTH     = MAX_DIM * MAX_DIM;
	localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int PROD_W    = 2 * DATA_W;
	localparam int ACC_W     = PROD_W + $clog2(MAX_DIM) + 1;
	localparam int SCL_STEPS = (ACC_W + DATA_W - 1) / DATA_W;
	localparam int STEP_W    = (SCL_STEPS > 1) ? $clog2(SCL_STEPS) : 1;
	localparam int EXT_W     = SCL_STEPS * DATA_W;
	localparam int RES_W     = ACC_W + DATA_W;
	localparam int SHIFT     = 2 * FRAC_BITS;

	localparam logic [CNT_W-1:0]  RST_DIM   = CNT_W'(8);
	localparam logic [DATA_W-1:0] RST_ALPHA = DATA_W'(1) << FRAC_BITS;

	typedef enum logic [FUNC_W-1:0] {
		FN_WR_A    = 3'd0,
		FN_WR_B    = 3'd1,
		FN_WR_C    = 3'd2,
		FN_COMPUTE = 3'd3,
		FN_RD_C    = 3'd4
	} func_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ROWS  = 3'd0,
		CFG_INNER = 3'd1,
		CFG_COLS  = 3'd2,
		CFG_ALPHA = 3'd3,
		CFG_ACC   = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [CNT_W-1:0]  rows;
		logic [CNT_W-1:0]  inner;
		logic [CNT_W-1:0]  cols;
		logic [DATA_W-1:0] alpha;
		logic              acc_mode;
	} cfg_t;

	typedef struct packed {
		logic                   a_we;
		logic                   b_we;
		logic                   c_we;
		logic                   c_wr_sel;
		logic [ADDR_W-1:0]      wr_addr;
		logic                   a_rd_en;
		logic                   b_rd_en;
		logic                   c_rd_en;
		logic [ADDR_W-1:0]      a_rd_addr;
		logic [ADDR_W-1:0]      b_rd_addr;
		logic [ADDR_W-1:0]      c_rd_addr;
		logic                   mac_issue;
		logic                   acc_clr;
		logic                   scl_issue;
		logic [STEP_W-1:0]      scl_step;
		logic                   sat_en;
		logic                   out_load;
		logic [FIELD_IDX_W-1:0] out_row;
		logic [FIELD_IDX_W-1:0] out_col;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} sts_t;

	function automatic logic [ADDR_W-1:0] mk_addr(input logic [IDX_W-1:0] r,
		input logic [IDX_W-1:0] c);
		logic [ADDR_W-1:0] a;
		a = ADDR_W'(r) * ADDR_W'(MAX_DIM) + ADDR_W'(c);
		return a;
	endfunction

endpackage

// ----- hdl/mmac_ram.sv -----
// generic single write port ram with registered read
module mmac_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- hdl/mmac_dp.sv -----
// datapath: matrix stores, multiply-accumulate, alpha scaling, saturation, result register
module mmac_dp import mmac_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cfg_t                   cfg,
	input  cmd_t                   cmd,
	input  logic [DATA_W-1:0]      data_value,
	input  logic                   m_ready,
	output logic                   m_valid,
	output logic [DATA_W-1:0]      read_value,
	output logic [FIELD_IDX_W-1:0] read_row,
	output logic [FIELD_IDX_W-1:0] read_col,
	output sts_t                   sts
);

	logic [DATA_W-1:0] a_rd;
	logic [DATA_W-1:0] b_rd;
	logic [DATA_W-1:0] c_rd;
	logic [DATA_W-1:0] c_wdata;

	mmac_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_a_ram (
		.clk     (clk),
		.we      (cmd.a_we),
		.wr_addr (cmd.wr_addr),
		.wr_data (data_value),
		.rd_en   (cmd.a_rd_en),
		.rd_addr (cmd.a_rd_addr),
		.rd_data (a_rd)
	);

	mmac_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_b_ram (
		.clk     (clk),
		.we      (cmd.b_we),
		.wr_addr (cmd.wr_addr),
		.wr_data (data_value),
		.rd_en   (cmd.b_rd_en),
		.rd_addr (cmd.b_rd_addr),
		.rd_data (b_rd)
	);

	mmac_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_c_ram (
		.clk     (clk),
		.we      (cmd.c_we),
		.wr_addr (cmd.wr_addr),
		.wr_data (c_wdata),
		.rd_en   (cmd.c_rd_en),
		.rd_addr (cmd.c_rd_addr),
		.rd_data (c_rd)
	);

	logic                       iss_s1;
	logic                       prod_v_s2;
	logic signed [PROD_W-1:0]   prod_s2;
	logic signed [ACC_W-1:0]    acc_q;

	logic                       scl_v_s1;
	logic                       scl_first_s1;
	logic [STEP_W-1:0]          scl_step_s1;
	logic signed [PROD_W:0]     scl_prod_s1;
	logic signed [RES_W-1:0]    res_q;

	logic signed [EXT_W-1:0]    acc_ext;
	logic [DATA_W-1:0]          chunk;
	logic signed [DATA_W:0]     chunk_op;
	logic signed [RES_W-1:0]    term;

	logic [RES_W-SHIFT-DATA_W:0] res_hi;
	logic [DATA_W-1:0]          sat_v;
	logic [DATA_W-1:0]          v_q;
	logic [DATA_W:0]            c_sum;
	logic [DATA_W-1:0]          c_sat;

	logic                       m_valid_q;
	logic [DATA_W-1:0]          read_value_q;
	logic [FIELD_IDX_W-1:0]     read_row_q;
	logic [FIELD_IDX_W-1:0]     read_col_q;

	localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	// alpha product is built from DATA_W-bit slices of the accumulator, top slice signed
	always_comb begin
		acc_ext  = EXT_W'(acc_q);
		chunk    = acc_ext[int'(cmd.scl_step)*DATA_W +: DATA_W];
		chunk_op = (cmd.scl_step == STEP_W'(SCL_STEPS - 1)) ?
			$signed({chunk[DATA_W-1], chunk}) : $signed({1'b0, chunk});
		term     = RES_W'(scl_prod_s1) <<< (int'(scl_step_s1) * DATA_W);
	end

	// arithmetic shift by SHIFT and clamp to DATA_W bits
	always_comb begin
		res_hi = res_q[RES_W-1:SHIFT+DATA_W-1];
		if ((&res_hi) || !(|res_hi)) begin
			sat_v = res_q[SHIFT+DATA_W-1:SHIFT];
		end else begin
			sat_v = res_q[RES_W-1] ? SAT_MIN : SAT_MAX;
		end
	end

	always_comb begin
		c_sum = {c_rd[DATA_W-1], c_rd} + {v_q[DATA_W-1], v_q};
		if (c_sum[DATA_W] != c_sum[DATA_W-1]) begin
			c_sat = c_sum[DATA_W] ? SAT_MIN : SAT_MAX;
		end else begin
			c_sat = c_sum[DATA_W-1:0];
		end
		if (cmd.c_wr_sel) begin
			c_wdata = cfg.acc_mode ? c_sat : v_q;
		end else begin
			c_wdata = data_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_s1    <= 1'b0;
			prod_v_s2 <= 1'b0;
			scl_v_s1  <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			iss_s1    <= cmd.mac_issue;
			prod_v_s2 <= iss_s1;
			scl_v_s1  <= cmd.scl_issue;
			if (cmd.out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_ready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (iss_s1) begin
			prod_s2 <= $signed(a_rd) * $signed(b_rd);
		end
		if (cmd.acc_clr) begin
			acc_q <= '0;
		end else if (prod_v_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
		if (cmd.scl_issue) begin
			scl_prod_s1  <= chunk_op * $signed(cfg.alpha);
			scl_step_s1  <= cmd.scl_step;
			scl_first_s1 <= (cmd.scl_step == '0);
		end
		if (scl_v_s1) begin
			res_q <= scl_first_s1 ? term : res_q + term;
		end
		if (cmd.sat_en) begin
			v_q <= sat_v;
		end
		if (cmd.out_load) begin
			read_value_q <= c_rd;
			read_row_q   <= cmd.out_row;
			read_col_q   <= cmd.out_col;
		end
	end

	assign m_valid      = m_valid_q;
	assign read_value   = read_value_q;
	assign read_row     = read_row_q;
	assign read_col     = read_col_q;
	assign sts.out_free = !m_valid_q || m_ready;

endmodule

// ----- hdl/mmac_ctrl.sv -----
// controller: item decode and element / inner-product sequencing
module mmac_ctrl import mmac_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cfg_t                   cfg,
	input  logic                   s_valid,
	output logic                   s_ready,
	input  logic [FUNC_W-1:0]      func,
	input  logic [FIELD_IDX_W-1:0] row_index,
	input  logic [FIELD_IDX_W-1:0] col_index,
	input  sts_t                   sts,
	output cmd_t                   cmd
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD_WAIT,
		ST_START,
		ST_MAC,
		ST_DRAIN,
		ST_SCALE,
		ST_SFLUSH,
		ST_FIN,
		ST_WRC
	} state_t;

	state_t                 state_q, state_d;
	logic [IDX_W-1:0]       i_q, i_d;
	logic [IDX_W-1:0]       j_q, j_d;
	logic [IDX_W-1:0]       k_q, k_d;
	logic [STEP_W-1:0]      cnt_q, cnt_d;
	logic [FIELD_IDX_W-1:0] rd_row_q, rd_row_d;
	logic [FIELD_IDX_W-1:0] rd_col_q, rd_col_d;

	logic [DIM_W-1:0]  rows_eff;
	logic [DIM_W-1:0]  inner_eff;
	logic [DIM_W-1:0]  cols_eff;
	logic              accept;
	logic              r_in_rows;
	logic              r_in_inner;
	logic              c_in_inner;
	logic              c_in_cols;
	logic [ADDR_W-1:0] in_addr;
	logic [ADDR_W-1:0] el_addr;

	function automatic logic [DIM_W-1:0] eff_dim(input logic [CNT_W-1:0] n);
		logic [DIM_W-1:0] d;
		if (int'(n) > MAX_DIM) begin
			d = DIM_W'(MAX_DIM);
		end else begin
			d = DIM_W'(n);
		end
		return d;
	endfunction

	always_comb begin
		rows_eff   = eff_dim(cfg.rows);
		inner_eff  = eff_dim(cfg.inner);
		cols_eff   = eff_dim(cfg.cols);
		s_ready    = (state_q == ST_IDLE);
		accept     = s_valid && s_ready;
		r_in_rows  = int'(row_index) < int'(rows_eff);
		r_in_inner = int'(row_index) < int'(inner_eff);
		c_in_inner = int'(col_index) < int'(inner_eff);
		c_in_cols  = int'(col_index) < int'(cols_eff);
		in_addr    = mk_addr(IDX_W'(row_index), IDX_W'(col_index));
		el_addr    = mk_addr(i_q, j_q);
	end

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		i_d      = i_q;
		j_d      = j_q;
		k_d      = k_q;
		cnt_d    = cnt_q;
		rd_row_d = rd_row_q;
		rd_col_d = rd_col_q;
		cmd.wr_addr   = in_addr;
		cmd.c_rd_addr = in_addr;
		cmd.a_rd_addr = mk_addr(i_q, k_q);
		cmd.b_rd_addr = mk_addr(k_q, j_q);
		cmd.scl_step  = cnt_q;
		cmd.out_row   = rd_row_q;
		cmd.out_col   = rd_col_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (func_t'(func))
						FN_WR_A: begin
							cmd.a_we = r_in_rows && c_in_inner;
						end
						FN_WR_B: begin
							cmd.b_we = r_in_inner && c_in_cols;
						end
						FN_WR_C: begin
							cmd.c_we = r_in_rows && c_in_cols;
						end
						FN_COMPUTE: begin
							if (rows_eff != '0 && cols_eff != '0) begin
								i_d     = '0;
								j_d     = '0;
								state_d = ST_START;
							end
						end
						FN_RD_C: begin
							if (r_in_rows && c_in_cols) begin
								cmd.c_rd_en = 1'b1;
								rd_row_d    = row_index;
								rd_col_d    = col_index;
								state_d     = ST_RD_WAIT;
							end
						end
						default: ;
					endcase
				end
			end
			ST_RD_WAIT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			ST_START: begin
				// old C(i,j) is fetched here and held for the final add
				cmd.acc_clr   = 1'b1;
				cmd.c_rd_en   = 1'b1;
				cmd.c_rd_addr = el_addr;
				k_d           = '0;
				cnt_d         = '0;
				state_d       = (inner_eff == '0) ? ST_DRAIN : ST_MAC;
			end
			ST_MAC: begin
				cmd.a_rd_en   = 1'b1;
				cmd.b_rd_en   = 1'b1;
				cmd.mac_issue = 1'b1;
				if (DIM_W'(k_q) == inner_eff - DIM_W'(1)) begin
					cnt_d   = '0;
					state_d = ST_DRAIN;
				end else begin
					k_d = k_q + IDX_W'(1);
				end
			end
			ST_DRAIN: begin
				// read and product stages empty into the accumulator
				if (cnt_q == STEP_W'(1)) begin
					cnt_d   = '0;
					state_d = ST_SCALE;
				end else begin
					cnt_d = cnt_q + STEP_W'(1);
				end
			end
			ST_SCALE: begin
				cmd.scl_issue = 1'b1;
				if (cnt_q == STEP_W'(SCL_STEPS - 1)) begin
					state_d = ST_SFLUSH;
				end else begin
					cnt_d = cnt_q + STEP_W'(1);
				end
			end
			ST_SFLUSH: begin
				state_d = ST_FIN;
			end
			ST_FIN: begin
				cmd.sat_en = 1'b1;
				state_d    = ST_WRC;
			end
			ST_WRC: begin
				cmd.c_we     = 1'b1;
				cmd.c_wr_sel = 1'b1;
				cmd.wr_addr  = el_addr;
				state_d      = ST_START;
				if (DIM_W'(j_q) == cols_eff - DIM_W'(1)) begin
					j_d = '0;
					if (DIM_W'(i_q) == rows_eff - DIM_W'(1)) begin
						state_d = ST_IDLE;
					end else begin
						i_d = i_q + IDX_W'(1);
					end
				end else begin
					j_d = j_q + IDX_W'(1);
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			i_q      <= '0;
			j_q      <= '0;
			k_q      <= '0;
			cnt_q    <= '0;
			rd_row_q <= '0;
			rd_col_q <= '0;
		end else begin
			state_q  <= state_d;
			i_q      <= i_d;
			j_q      <= j_d;
			k_q      <= k_d;
			cnt_q    <= cnt_d;
			rd_row_q <= rd_row_d;
			rd_col_q <= rd_col_d;
		end
	end

	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.a_we, cmd.b_we, cmd.c_we}))
		else $error("more than one store written in a cycle");

	a_result_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.c_we && cmd.c_wr_sel) |-> !s_ready)
		else $error("computed C written while input side is open");

	a_out_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("result register overwritten before transfer");

	a_mac_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mac_issue |-> (int'(k_q) < int'(inner_eff) && int'(j_q) < int'(cols_eff)
			&& int'(i_q) < int'(rows_eff)))
		else $error("inner product index outside configured size");

	a_start_after_compute: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && func == FN_COMPUTE && rows_eff != '0 && cols_eff != '0)
			|=> (state_q == ST_START && i_q == '0 && j_q == '0))
		else $error("compute did not start at the first element");

endmodule

// ----- hdl/matrix_multiply_accumulate.sv -----
// top level of the matrix multiply-accumulate engine: ports, configuration registers
//
//  channel   direction  handshake              payload
//  s_*       in         s_tvalid / s_tready    s_tuser func, s_tdata row, col, value
//  m_*       out        m_tvalid / m_tready    m_tdata read value, row, col
//  cfg_*     in         cfg_valid / cfg_ready  cfg_index register, cfg_data value
//
// element writes are taken back to back; a read of C holds the input side until its result is loaded
// a compute walks every element of C in turn: per element one C fetch, inner
// multiply-accumulate steps, a pipeline drain, three alpha slices through one
// 33x32 multiplier, the final sum, saturation and one write to the C store
// reset clears control state only; the stores hold nothing defined until written
// a stalled result sits in the output register while writes keep flowing in
module matrix_multiply_accumulate import mmac_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [TDATA_W-1:0]   s_tdata,    // row_index, col_index, data_value, zero fill
	input  logic [FUNC_W-1:0]    s_tuser,    // func
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [TDATA_W-1:0]   m_tdata,    // read_value, read_row, read_col, zero fill
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DATA_W-1:0]    cfg_data
);

	cfg_t cfg_q;
	cmd_t cmd;
	sts_t sts;

	logic [DATA_W-1:0]      read_value;
	logic [FIELD_IDX_W-1:0] read_row;
	logic [FIELD_IDX_W-1:0] read_col;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rows     <= RST_DIM;
			cfg_q.inner    <= RST_DIM;
			cfg_q.cols     <= RST_DIM;
			cfg_q.alpha    <= RST_ALPHA;
			cfg_q.acc_mode <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_ROWS:  cfg_q.rows     <= cfg_data[CNT_W-1:0];
				CFG_INNER: cfg_q.inner    <= cfg_data[CNT_W-1:0];
				CFG_COLS:  cfg_q.cols     <= cfg_data[CNT_W-1:0];
				CFG_ALPHA: cfg_q.alpha    <= cfg_data;
				CFG_ACC:   cfg_q.acc_mode <= cfg_data[0];
				default: ;
			endcase
		end
	end

	mmac_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.s_valid   (s_tvalid),
		.s_ready   (s_tready),
		.func      (s_tuser),
		.row_index (s_tdata[FIELD_IDX_W-1:0]),
		.col_index (s_tdata[2*FIELD_IDX_W-1:FIELD_IDX_W]),
		.sts       (sts),
		.cmd       (cmd)
	);

	mmac_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.cmd        (cmd),
		.data_value (s_tdata[2*FIELD_IDX_W+DATA_W-1:2*FIELD_IDX_W]),
		.m_ready    (m_tready),
		.m_valid    (m_tvalid),
		.read_value (read_value),
		.read_row   (read_row),
		.read_col   (read_col),
		.sts        (sts)
	);

	assign m_tdata = {{(TDATA_W - DATA_W - 2*FIELD_IDX_W){1'b0}}, read_col, read_row, read_value};

endmodule

// ----- test/matrix_multiply_accumulate_test.sv -----
// self-checking testbench for the matrix multiply-accumulate engine
module matrix_multiply_accumulate_test;
	import mmac_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int V_MAX = 32'h7FFF_FFFF;
	localparam int V_MIN = 32'h8000_0000;
	localparam logic [FUNC_W-1:0] FN_SPARE_FIRST = 3'd5;
	localparam logic [FUNC_W-1:0] FN_SPARE_LAST  = 3'd7;
	localparam int ITEMS_PER_PHASE = 18;
	localparam int PHASE_COUNT     = 10;

	typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

	typedef struct packed {
		row_kind_t         kind;
		logic [2:0]        code;    // register index or func
		logic [2:0]        row;
		logic [2:0]        col;
		logic [DATA_W-1:0] value;
		logic              known;
		logic [DATA_W-1:0] want;
	} step_t;

	typedef struct packed {
		logic [CNT_W-1:0]  rows;
		logic [CNT_W-1:0]  inner;
		logic [CNT_W-1:0]  cols;
		logic [DATA_W-1:0] alpha;
		logic              acc;
	} setting_t;

	typedef struct packed {
		logic [DATA_W-1:0] value;
		logic [2:0]        row;
		logic [2:0]        col;
	} c_read_t;

	localparam step_t DIRECTED [0:26] = '{
		'{ROW_CFG,  CFG_ROWS,       0, 0, 32'd1,        1'b0, 32'd0},
		'{ROW_CFG,  CFG_INNER,      0, 0, 32'd1,        1'b0, 32'd0},
		'{ROW_CFG,  CFG_COLS,       0, 0, 32'd1,        1'b0, 32'd0},
		'{ROW_ITEM, FN_WR_A,        0, 0, V_MAX,        1'b0, 32'd0},
		'{ROW_ITEM, FN_WR_B,        0, 0, V_MIN,        1'b0, 32'd0},
		'{ROW_ITEM, FN_WR_C,        0, 0, 32'h0001_0000, 1'b0, 32'd0},
		'{ROW_ITEM, FN_RD_C,        0, 0, 32'd0,        1'b1, 32'h0001_0000},
		// writes and reads outside the configured sizes and spare func codes are dropped
		'{ROW_ITEM, FN_WR_C,        1, 0, 32'h1234_5678, 1'b0, 32'd0},
		'{ROW_ITEM, FN_WR_B,        1, 0, 32'h1234_5678, 1'b0, 32'd0},
		'{ROW_ITEM, FN_RD_C,        0, 1, 32'd0,        1'b0, 32'd0},
		'{ROW_ITEM, FN_SPARE_FIRST, 0, 0, 32'hFFFF_FFFF, 1'b0, 32'd0},
		'{ROW_ITEM, FN_SPARE_LAST,  7, 7, 32'hFFFF_FFFF, 1'b0, 32'd0},
		// max times min saturates low, then the accumulate adds one; max times max saturates high
		'{ROW_ITEM, FN_COMPUTE,     0, 0, 32'd0,        1'b0, 32'd0},
		'{ROW_ITEM, FN_RD_C,        0, 0, 32'd0,        1'b0, 32'd0},
		'{ROW_CFG,  CFG_ACC,        0, 0, 32'd0,        1'b0, 32'd0},
		'{ROW_CFG,  CFG_ALPHA,      0, 0, V_MAX,        1'b0, 32'd0},
		'{ROW_ITEM, FN_WR_B,        0, 0, V_MAX,        1'b0, 32'd0},
		'{ROW_ITEM, FN_COMPUTE,     0, 0, 32'd0,        1'b0, 32'd0},
		'{ROW_ITEM, FN_RD_C,        0, 0, 32'd0,        1'b1, V_MAX},
		// zero rows: reads give nothing and compute leaves C alone
		'{ROW_CFG,  CFG_ROWS,       0, 0, 32'd0,        1'b0, 32'd0},
		'{ROW_ITEM, FN_RD_C,        0, 0, 32'd0,        1'b0, 32'd0},
		'{ROW_ITEM, FN_COMPUTE,     0, 0, 32'd0,        1'b0, 32'd0},
		'{ROW_CFG,  CFG_ROWS,       0, 0, 32'd1,        1'b0, 32'd0},
		'{ROW_ITEM, FN_RD_C,        0, 0, 32'd0,        1'b1, V_MAX},
		// zero inner count gives a zero dot product
		'{ROW_CFG,  CFG_INNER,      0, 0, 32'd0,        1'b0, 32'd0},
		'{ROW_ITEM, FN_COMPUTE,     0, 0, 32'd0,        1'b0, 32'd0},
		'{ROW_ITEM, FN_RD_C,        0, 0, 32'd0,        1'b1, 32'd0}
	};

	localparam setting_t PHASE_PLAN [0:6] = '{
		'{4'd8,  4'd8,  4'd8,  RST_ALPHA,     1'b1},
		'{4'd3,  4'd5,  4'd2,  32'h0000_8000, 1'b0},
		'{4'd1,  4'd1,  4'd1,  V_MAX,         1'b1},
		'{4'd15, 4'd15, 4'd15, V_MIN,         1'b0},
		'{4'd0,  4'd4,  4'd3,  32'hFFFE_0000, 1'b1},
		'{4'd4,  4'd0,  4'd4,  RST_ALPHA,     1'b1},
		'{4'd5,  4'd3,  4'd0,  32'h0003_4000, 1'b0}
	};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [TDATA_W-1:0]   s_tdata = '0;
	logic [FUNC_W-1:0]    s_tuser = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [TDATA_W-1:0]   m_tdata;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [DATA_W-1:0]    cfg_data = '0;

	// predictor state
	int mat_a [0:MAX_DIM-1][0:MAX_DIM-1];
	int mat_b [0:MAX_DIM-1][0:MAX_DIM-1];
	int mat_c [0:MAX_DIM-1][0:MAX_DIM-1];
	logic [CNT_W-1:0] cur_rows = RST_DIM;
	logic [CNT_W-1:0] cur_inner = RST_DIM;
	logic [CNT_W-1:0] cur_cols = RST_DIM;
	int               cur_alpha = RST_ALPHA;
	logic             cur_acc = 1'b1;

	c_read_t pending_reads [$];
	int      error_count = 0;
	int      reads_checked = 0;
	int      items_sent = 0;
	int      computes_sent = 0;
	int      settle = 4;
	bit      steady = 1'b0;

	matrix_multiply_accumulate dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int eff_dim(input logic [CNT_W-1:0] n);
		return (n > MAX_DIM) ? MAX_DIM : int'(n);
	endfunction

	function automatic logic [DATA_W-1:0] rand_value();
		case ($urandom_range(0, 9))
			0: return V_MAX;
			1: return V_MIN;
			2: return '0;
			3, 4: return $urandom;
			default: return int'($urandom_range(0, 2097152)) - 1048576;
		endcase
	endfunction

	// mostly inside the configured size, now and then anywhere
	function automatic logic [2:0] rand_index(input int lim);
		if (lim == 0 || $urandom_range(0, 9) == 0)
			return 3'($urandom_range(0, MAX_DIM - 1));
		return 3'($urandom_range(0, lim - 1));
	endfunction

	task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
		input logic [DATA_W-1:0] want);
		$display("%0t ns: mismatch in %s: got %h, expected %h", $realtime, what, got, want);
		error_count++;
	endtask

	task automatic gemm_update();
		logic signed [127:0] dot;
		logic signed [127:0] wa;
		logic signed [127:0] wb;
		logic signed [127:0] scaled;
		int                  v;
		longint              s;
		for (int i = 0; i < eff_dim(cur_rows); i++) begin
			for (int j = 0; j < eff_dim(cur_cols); j++) begin
				dot = '0;
				for (int k = 0; k < eff_dim(cur_inner); k++) begin
					wa = 128'(mat_a[i][k]);
					wb = 128'(mat_b[k][j]);
					dot = dot + wa * wb;
				end
				wa = 128'(cur_alpha);
				scaled = (dot * wa) >>> SHIFT;
				if (scaled > V_MAX)
					v = V_MAX;
				else if (scaled < V_MIN)
					v = V_MIN;
				else
					v = scaled[31:0];
				if (cur_acc) begin
					s = longint'(mat_c[i][j]) + longint'(v);
					v = (s > V_MAX) ? V_MAX : (s < V_MIN) ? V_MIN : int'(s);
				end
				mat_c[i][j] = v;
			end
		end
	endtask

	// applies one accepted item, returns whether the block does anything with it; a compute always counts
	task automatic apply_item(input logic [FUNC_W-1:0] fn, input logic [2:0] r,
		input logic [2:0] c, input logic [DATA_W-1:0] d, output bit has_read,
		output int read_val, output bit effective);
		int rows;
		int inner;
		int cols;
		rows = eff_dim(cur_rows);
		inner = eff_dim(cur_inner);
		cols = eff_dim(cur_cols);
		has_read = 1'b0;
		read_val = 0;
		effective = 1'b0;
		case (fn)
			FN_WR_A: if (r < rows && c < inner) begin
				mat_a[r][c] = d;
				effective = 1'b1;
			end
			FN_WR_B: if (r < inner && c < cols) begin
				mat_b[r][c] = d;
				effective = 1'b1;
			end
			FN_WR_C: if (r < rows && c < cols) begin
				mat_c[r][c] = d;
				effective = 1'b1;
			end
			FN_COMPUTE: begin
				gemm_update();
				effective = 1'b1;
			end
			FN_RD_C: if (r < rows && c < cols) begin
				has_read = 1'b1;
				read_val = mat_c[r][c];
				effective = 1'b1;
			end
			default: ;
		endcase
	endtask

	task automatic send_item(input logic [FUNC_W-1:0] fn, input logic [2:0] r,
		input logic [2:0] c, input logic [DATA_W-1:0] d, input bit known,
		input logic [DATA_W-1:0] want, output bit effective);
		bit      has_read;
		int      read_val;
		c_read_t entry;
		while (!steady && $urandom_range(0, 99) < 15) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= fn;
		s_tdata <= {2'b00, d, c, r};
		do
			@(posedge clk);
		while (!s_tready);
		items_sent++;
		apply_item(fn, r, c, d, has_read, read_val, effective);
		if (has_read) begin
			entry.value = known ? want : read_val;
			entry.row = r;
			entry.col = c;
			pending_reads.push_back(entry);
		end
		if (fn == FN_COMPUTE) begin
			computes_sent++;
			settle = eff_dim(cur_rows) * eff_dim(cur_cols) * (eff_dim(cur_inner) + 9) + 16;
		end
	endtask

	// quiet the input side and let any compute finish
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending_reads.size() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
		settle = 4;
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_ROWS:  cur_rows = val[CNT_W-1:0];
			CFG_INNER: cur_inner = val[CNT_W-1:0];
			CFG_COLS:  cur_cols = val[CNT_W-1:0];
			CFG_ALPHA: cur_alpha = val;
			CFG_ACC:   cur_acc = val[0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic apply_setting(input setting_t st);
		wait_idle();
		write_reg(CFG_ROWS, DATA_W'(st.rows));
		write_reg(CFG_INNER, DATA_W'(st.inner));
		write_reg(CFG_COLS, DATA_W'(st.cols));
		write_reg(CFG_ALPHA, st.alpha);
		write_reg(CFG_ACC, DATA_W'(st.acc));
	endtask

	task automatic random_item(output bit effective);
		logic [FUNC_W-1:0] fn;
		logic [2:0]        r;
		logic [2:0]        c;
		int                pick;
		pick = $urandom_range(0, 99);
		if (pick < 18) begin
			fn = FN_WR_A;
			r = rand_index(eff_dim(cur_rows));
			c = rand_index(eff_dim(cur_inner));
		end else if (pick < 36) begin
			fn = FN_WR_B;
			r = rand_index(eff_dim(cur_inner));
			c = rand_index(eff_dim(cur_cols));
		end else if (pick < 48 || pick >= 56 && pick < 94) begin
			fn = (pick < 48) ? FN_WR_C : FN_RD_C;
			r = rand_index(eff_dim(cur_rows));
			c = rand_index(eff_dim(cur_cols));
		end else begin
			fn = (pick < 56) ? FN_COMPUTE : FUNC_W'($urandom_range(FN_SPARE_FIRST, FN_SPARE_LAST));
			r = 3'($urandom_range(0, MAX_DIM - 1));
			c = 3'($urandom_range(0, MAX_DIM - 1));
		end
		send_item(fn, r, c, rand_value(), 1'b0, '0, effective);
	endtask

	// result side: random backpressure outside the steady stretch
	always @(posedge clk)
		m_tready <= steady || ($urandom_range(0, 99) >= 15);

	always @(posedge clk) begin
		c_read_t exp_read;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_reads.size() == 0) begin
				report_mismatch("unexpected result transfer", m_tdata[31:0], '0);
			end else begin
				exp_read = pending_reads.pop_front();
				reads_checked++;
				if (m_tdata[31:0] != exp_read.value)
					report_mismatch("read_value", m_tdata[31:0], exp_read.value);
				if (m_tdata[34:32] != exp_read.row)
					report_mismatch("read_row", DATA_W'(m_tdata[34:32]), DATA_W'(exp_read.row));
				if (m_tdata[37:35] != exp_read.col)
					report_mismatch("read_col", DATA_W'(m_tdata[37:35]), DATA_W'(exp_read.col));
			end
		end
	end

	initial begin : timeout
		#10_000_000;
		$display("timeout with %0d reads still outstanding", pending_reads.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin : main_seq
		bit       eff;
		int       done;
		setting_t st;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[n]) begin
			if (DIRECTED[n].kind == ROW_CFG) begin
				wait_idle();
				write_reg(cfg_reg_t'(DIRECTED[n].code), DIRECTED[n].value);
			end else begin
				send_item(DIRECTED[n].code, DIRECTED[n].row, DIRECTED[n].col,
					DIRECTED[n].value, DIRECTED[n].known, DIRECTED[n].want, eff);
			end
		end

		// fill all three stores so no later read touches an unwritten entry
		apply_setting('{RST_DIM, RST_DIM, RST_DIM, RST_ALPHA, 1'b1});
		for (int r = 0; r < MAX_DIM; r++) begin
			for (int c = 0; c < MAX_DIM; c++) begin
				send_item(FN_WR_A, 3'(r), 3'(c), rand_value(), 1'b0, '0, eff);
				send_item(FN_WR_B, 3'(r), 3'(c), rand_value(), 1'b0, '0, eff);
				send_item(FN_WR_C, 3'(r), 3'(c), rand_value(), 1'b0, '0, eff);
			end
		end

		for (int ph = 0; ph < PHASE_COUNT; ph++) begin
			if (ph < 7) begin
				st = PHASE_PLAN[ph];
			end else begin
				st.rows = CNT_W'($urandom_range(1, MAX_DIM));
				st.inner = CNT_W'($urandom_range(1, MAX_DIM));
				st.cols = CNT_W'($urandom_range(1, MAX_DIM));
				st.alpha = ($urandom_range(0, 3) == 0) ? $urandom
					: int'($urandom_range(0, 524288)) - 262144;
				st.acc = 1'($urandom_range(0, 1));
			end
			apply_setting(st);
			steady = (ph == 2 || ph == 3);
			done = 0;
			while (done < ITEMS_PER_PHASE) begin
				random_item(eff);
				done += eff;
			end
		end
		steady = 1'b0;
		wait_idle();

		$display("run covered %0d input transfers, %0d computes and %0d checked C reads",
			items_sent, computes_sent, reads_checked);
		$display("over %0d register settings, zero and oversize dimensions included",
			PHASE_COUNT + 1);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
